@@ src/dda_pkg.sv @@
package dda_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 10;
    localparam int SCALE_W   = 5;
    localparam int PAD_W     = 10;
    localparam int CFG_W     = 10;
    localparam int MAP_W     = 16;
    localparam int DELTA_W   = MAP_W + 1;
    localparam int STEP_W    = 15;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int INC_W     = FRAC_BITS + 2;
    localparam int CUR_W     = 32;
    localparam int OUT_W     = 31;
    localparam int CNT_W     = $clog2(FRAC_BITS + 1);

    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(5);
    localparam logic [PAD_W-1:0]   PAD_RST   = PAD_W'(250);

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_PAD   = 1'b1;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef struct packed {
        logic load;
        logic delta;
        logic steps;
        logic div_step;
        logic emit_start;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic steps_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

@@ src/dda_line_rasterizer.sv @@
// DDA line rasterizer.
// Input channel: i_valid / o_stall carry one word: i_mode plus two endpoints.
//   Mode start (0) maps each coordinate to c * scale + pad and begins a line;
//   mode advance (1) steps the active line by one point.
// Output channel: o_valid / o_stall's partner i_stall carry one point word
//   (o_point_x, o_point_y with FRAC_BITS fraction bits, o_last).
// Config: i_cfg_we writes register i_cfg_idx (0 scale, 1 pad) from i_cfg_data;
//   write only while no line set-up is in flight.
// Start word: map, delta, step-count stages, then a radix-2 restoring divide
//   of FRAC_BITS + 1 iterations run on both axes at once; an emit state
//   that waits for a free output registers the start point, and the next
//   word can be taken once it is valid. A new word is refused during that
//   set-up. A zero-length line skips the divide and emits one last point.
// Advance word: one point per cycle when not stalled, valid the cycle after
//   acceptance; an advance with no active line is taken and produces nothing.
// The output is one register: while it is stalled, a new word is accepted
//   only in the cycle the waiting point leaves; a stalled point holds.
// Reset (synchronous, active low) restores scale 5 and pad 250, drops any
//   active line and clears the output valid.
module dda_line_rasterizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [dda_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic signed [dda_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [dda_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [dda_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [dda_pkg::COORD_W-1:0] i_y_end,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [dda_pkg::OUT_W-1:0]   o_point_x,
    output logic signed [dda_pkg::OUT_W-1:0]   o_point_y,
    output logic                               o_last
);
    import dda_pkg::*;

    t_cmd    cmd;
    t_status status;

    dda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    dda_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .i_cmd      (cmd),
        .i_stall    (i_stall),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_last     (o_last)
    );

endmodule

@@ src/dda_ctrl.sv @@
module dda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_mode,
    input  dda_pkg::t_status i_status,
    output logic             o_stall,
    output dda_pkg::t_cmd    o_cmd
);
    import dda_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_STEPS = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       take;

    assign take    = (r_state == S_IDLE) && i_status.out_free;
    assign o_stall = !take;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && take) begin
                    if (i_mode == MODE_START) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DELTA;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = S_STEPS;
            end
            S_STEPS: begin
                o_cmd.steps = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (i_status.steps_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_done) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/dda_dp.sv @@
module dda_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [dda_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [dda_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [dda_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [dda_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [dda_pkg::COORD_W-1:0] i_y_end,
    input  dda_pkg::t_cmd                     i_cmd,
    input  logic                              i_stall,
    output dda_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic signed [dda_pkg::OUT_W-1:0]  o_point_x,
    output logic signed [dda_pkg::OUT_W-1:0]  o_point_y,
    output logic                              o_last
);
    import dda_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [PAD_W-1:0]   r_pad;

    logic signed [MAP_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [MAP_W-1:0] m_x1, m_y1, m_x2, m_y2;
    logic signed [SCALE_W:0] scale_s;
    logic signed [MAP_W-1:0] pad_s;

    logic signed [DELTA_W-1:0] dx, dy;
    logic [STEP_W-1:0] r_ax, r_ay, r_steps, r_rem_x, r_rem_y, r_steps_left;
    logic              r_neg_x, r_neg_y, r_zero;
    logic [Q_W-1:0]    r_q_x, r_q_y;
    logic [CNT_W-1:0]  r_cnt;

    logic signed [CUR_W-1:0] r_cur_x, r_cur_y;
    logic signed [INC_W-1:0] r_inc_x, r_inc_y;
    logic                    r_active;
    logic                    r_ovalid;

    logic [STEP_W-1:0] rem_x_n, rem_y_n;
    logic              bit_x, bit_y;
    logic              first;
    logic              adv_go;
    logic              last_step;

    function automatic logic [STEP_W:0] div_iter(input logic [STEP_W-1:0] rem,
                                                 input logic [STEP_W-1:0] den,
                                                 input logic              no_shift);
        logic [STEP_W:0] tmp;
        logic [STEP_W:0] diff;
        logic            ge;
        tmp  = no_shift ? {1'b0, rem} : {rem, 1'b0};
        diff = tmp - {1'b0, den};
        ge   = (tmp >= {1'b0, den});
        return ge ? {1'b1, diff[STEP_W-1:0]} : {1'b0, tmp[STEP_W-1:0]};
    endfunction

    function automatic logic signed [INC_W-1:0] apply_sign(input logic [Q_W-1:0] q,
                                                            input logic           neg);
        logic signed [INC_W-1:0] v;
        v = $signed({1'b0, q});
        return neg ? -v : v;
    endfunction

    assign scale_s = $signed({1'b0, r_scale});
    assign pad_s   = $signed(MAP_W'(r_pad));
    assign m_x1    = MAP_W'(i_x_start * scale_s) + pad_s;
    assign m_y1    = MAP_W'(i_y_start * scale_s) + pad_s;
    assign m_x2    = MAP_W'(i_x_end * scale_s) + pad_s;
    assign m_y2    = MAP_W'(i_y_end * scale_s) + pad_s;

    assign dx = DELTA_W'(r_x2) - DELTA_W'(r_x1);
    assign dy = DELTA_W'(r_y2) - DELTA_W'(r_y1);

    assign first            = (r_cnt == '0);
    assign {bit_x, rem_x_n} = div_iter(r_rem_x, r_steps, first);
    assign {bit_y, rem_y_n} = div_iter(r_rem_y, r_steps, first);

    assign adv_go    = i_cmd.advance && r_active;
    assign last_step = (r_steps_left == STEP_W'(1));

    assign o_status.steps_zero = r_zero;
    assign o_status.div_done   = (r_cnt == CNT_W'(FRAC_BITS));
    assign o_status.out_free   = !r_ovalid || !i_stall;

    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_pad   <= PAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_PAD:   r_pad   <= i_cfg_data[PAD_W-1:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    // start set-up: map, deltas, step count, then the shared-time divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1 <= m_x1;
            r_y1 <= m_y1;
            r_x2 <= m_x2;
            r_y2 <= m_y2;
        end
        if (i_cmd.delta) begin
            r_neg_x <= dx[DELTA_W-1];
            r_neg_y <= dy[DELTA_W-1];
            r_ax    <= dx[DELTA_W-1] ? STEP_W'(-dx) : STEP_W'(dx);
            r_ay    <= dy[DELTA_W-1] ? STEP_W'(-dy) : STEP_W'(dy);
        end
        if (i_cmd.steps) begin
            r_steps <= (r_ax > r_ay) ? r_ax : r_ay;
            r_zero  <= (r_ax == '0) && (r_ay == '0);
            r_rem_x <= r_ax;
            r_rem_y <= r_ay;
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_cnt   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem_x <= rem_x_n;
            r_rem_y <= rem_y_n;
            r_q_x   <= {r_q_x[Q_W-2:0], bit_x};
            r_q_y   <= {r_q_y[Q_W-2:0], bit_y};
            r_cnt   <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_cur_x   <= CUR_W'(r_x1) <<< FRAC_BITS;
            r_cur_y   <= CUR_W'(r_y1) <<< FRAC_BITS;
            r_inc_x   <= apply_sign(r_q_x, r_neg_x);
            r_inc_y   <= apply_sign(r_q_y, r_neg_y);
            o_point_x <= OUT_W'(CUR_W'(r_x1) <<< FRAC_BITS);
            o_point_y <= OUT_W'(CUR_W'(r_y1) <<< FRAC_BITS);
            o_last    <= r_zero;
        end else if (adv_go) begin
            r_cur_x   <= r_cur_x + CUR_W'(r_inc_x);
            r_cur_y   <= r_cur_y + CUR_W'(r_inc_y);
            o_point_x <= OUT_W'(r_cur_x + CUR_W'(r_inc_x));
            o_point_y <= OUT_W'(r_cur_y + CUR_W'(r_inc_y));
            o_last    <= last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_steps_left <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cmd.emit_start) begin
                r_active     <= !r_zero;
                r_steps_left <= r_steps;
            end else if (adv_go) begin
                r_steps_left <= r_steps_left - STEP_W'(1);
                if (last_step) begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.emit_start || adv_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

@@ sim/dda_line_rasterizer_tb.sv @@
module dda_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 2 * (FRAC_BITS + 5);
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 165;

    typedef struct {
        logic                      mode;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
    } t_line_word;

    typedef struct {
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic                    last;
    } t_point;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_cfg_we   = 1'b0;
    logic                      i_cfg_idx  = REG_SCALE;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      i_valid    = 1'b0;
    logic                      o_stall;
    logic                      i_mode     = MODE_ADVANCE;
    logic signed [COORD_W-1:0] i_x_start  = '0;
    logic signed [COORD_W-1:0] i_y_start  = '0;
    logic signed [COORD_W-1:0] i_x_end    = '0;
    logic signed [COORD_W-1:0] i_y_end    = '0;
    logic                      o_valid;
    logic                      i_stall    = 1'b0;
    logic signed [OUT_W-1:0]   o_point_x;
    logic signed [OUT_W-1:0]   o_point_y;
    logic                      o_last;

    dda_line_rasterizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_last     (o_last)
    );

    // shadow of the block's registers and line state
    logic [SCALE_W-1:0] scale_reg   = SCALE_RST;
    logic [PAD_W-1:0]   pad_reg     = PAD_RST;
    logic signed [31:0] pos_x       = '0;
    logic signed [31:0] pos_y       = '0;
    longint             inc_x       = 0;
    longint             inc_y       = 0;
    logic [STEP_W-1:0]  steps_left  = '0;
    logic               line_active = 1'b0;

    t_line_word pending_words[$];
    t_point     expected_points[$];
    int         mismatches     = 0;
    int         cycles         = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("dda_line_rasterizer: mismatch");
            $finish;
        end
    end

    function automatic longint scaled_coord(logic signed [COORD_W-1:0] c);
        return longint'(c) * longint'(scale_reg) + longint'(pad_reg);
    endfunction

    function automatic longint line_steps(t_line_word w);
        longint dx;
        longint dy;
        dx = scaled_coord(w.xe) - scaled_coord(w.xs);
        dy = scaled_coord(w.ye) - scaled_coord(w.ys);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx > dy) ? dx : dy;
    endfunction

    // Q.16 increment, truncated toward zero
    function automatic longint step_increment(longint d, longint n);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = (mag << FRAC_BITS) / n;
        return (d < 0) ? -q : q;
    endfunction

    task automatic rasterize_word(input t_line_word w);
        longint n;
        logic   fin;
        if (w.mode == MODE_START) begin
            n = line_steps(w);
            pos_x = 32'(scaled_coord(w.xs) << FRAC_BITS);
            pos_y = 32'(scaled_coord(w.ys) << FRAC_BITS);
            if (n == 0) begin
                inc_x = 0;
                inc_y = 0;
                steps_left = '0;
                line_active = 1'b0;
                fin = 1'b1;
            end else begin
                inc_x = step_increment(scaled_coord(w.xe) - scaled_coord(w.xs), n);
                inc_y = step_increment(scaled_coord(w.ye) - scaled_coord(w.ys), n);
                steps_left = n[STEP_W-1:0];
                line_active = 1'b1;
                fin = 1'b0;
            end
        end else begin
            if (!line_active) return;
            pos_x = pos_x + 32'(inc_x);
            pos_y = pos_y + 32'(inc_y);
            steps_left = steps_left - 1'b1;
            fin = (steps_left == 0);
            if (fin) line_active = 1'b0;
        end
        expected_points.push_back('{px: pos_x[OUT_W-1:0], py: pos_y[OUT_W-1:0], last: fin});
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : drive_words
        t_line_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                rasterize_word('{mode: i_mode, xs: i_x_start, ys: i_y_start,
                                 xe: i_x_end, ye: i_y_end});
            end
            if (i_valid && o_stall) begin
                // stalled word holds
            end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                i_valid   <= 1'b1;
                i_mode    <= w.mode;
                i_x_start <= w.xs;
                i_y_start <= w.ys;
                i_x_end   <= w.xe;
                i_y_end   <= w.ye;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_points
        t_point want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    flag_mismatch("point with nothing expected", o_point_x, 0);
                end else begin
                    want = expected_points.pop_front();
                    if (o_point_x !== want.px) flag_mismatch("point_x", o_point_x, want.px);
                    if (o_point_y !== want.py) flag_mismatch("point_y", o_point_y, want.py);
                    if (o_last !== want.last) flag_mismatch("last", o_last, want.last);
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_line_word start_word(int xs, int ys, int xe, int ye);
        return '{mode: MODE_START, xs: COORD_W'(xs), ys: COORD_W'(ys),
                 xe: COORD_W'(xe), ye: COORD_W'(ye)};
    endfunction

    function automatic t_line_word advance_word();
        return '{mode: MODE_ADVANCE, xs: COORD_W'($urandom), ys: COORD_W'($urandom),
                 xe: COORD_W'($urandom), ye: COORD_W'($urandom)};
    endfunction

    function automatic int near_coord(int c);
        int d;
        int e;
        d = int'($urandom_range(6)) - 3;
        e = c + d;
        if (e > 511 || e < -512) e = c - d;
        return e;
    endfunction

    task automatic queue_random_lines(input int target);
        int         counted;
        int         n_adv;
        int         xs;
        int         ys;
        longint     n;
        t_line_word w;
        counted = 0;
        while (counted < target) begin
            xs = int'($urandom_range(1023)) - 512;
            ys = int'($urandom_range(1023)) - 512;
            if ($urandom_range(99) < 15)
                w = start_word(xs, ys, int'($urandom_range(1023)) - 512,
                               int'($urandom_range(1023)) - 512);
            else
                w = start_word(xs, ys, near_coord(xs), near_coord(ys));
            pending_words.push_back(w);
            counted++;
            n = line_steps(w);
            if (n > 200) n_adv = $urandom_range(20);
            else if ($urandom_range(99) < 75) n_adv = int'(n);
            else n_adv = $urandom_range(int'(n));
            repeat (n_adv) pending_words.push_back(advance_word());
            counted += n_adv;
            // stray advances after a finished line
            if (n_adv == n && $urandom_range(99) < 30)
                repeat ($urandom_range(1, 3)) pending_words.push_back(advance_word());
        end
    endtask

    task automatic settle();
        while (pending_words.size() != 0 || i_valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        if (idx == REG_SCALE) scale_reg = SCALE_W'(value);
        else pad_reg = PAD_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : run
        int scales[PHASES];
        int pads[PHASES];
        scales = '{1, 16, 0, 31, 17, 5, 0, 0};
        pads   = '{0, 1023, 512, 1023, 0, 250, 0, 0};
        scales[6] = $urandom_range(1, 16);
        scales[7] = $urandom_range(1, 16);
        pads[6]   = $urandom_range(1023);
        pads[7]   = $urandom_range(1023);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_words.push_back(advance_word());
        pending_words.push_back(start_word(7, -3, 7, -3));
        pending_words.push_back(start_word(-512, -512, 511, 511));
        repeat (2) pending_words.push_back(advance_word());
        pending_words.push_back(start_word(511, -512, -512, 511));
        pending_words.push_back(advance_word());
        pending_words.push_back(start_word(0, 0, 2, -1));
        repeat (11) pending_words.push_back(advance_word());
        settle();

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            write_reg(REG_SCALE, scales[p]);
            write_reg(REG_PAD, pads[p]);
            case (p % 4)
                1: send_idle_pct = 84;
                2: recv_stall_pct = 84;
                3: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
                default: ;
            endcase
            queue_random_lines(PHASE_WORDS);
            settle();
        end

        if (mismatches == 0 && expected_points.size() == 0)
            $display("dda_line_rasterizer: match");
        else
            $display("dda_line_rasterizer: mismatch");
        $finish;
    end

endmodule
